@@ sv/dnhf_pkg.sv @@
// Shared types, constants and helpers for the diagonal-neighbor hole fill block.
`timescale 1ns / 1ps
package dnhf_pkg;

    // Geometry defaults and limits
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int CFG_W          = 11;
    localparam int MIN_DIM        = 3;
    localparam int RESET_DIM      = 1024;

    // Register indexes of the configuration port
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // Input request kinds
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    // Q1.14 pixel codes
    localparam logic signed [15:0] HOLE_VALUE = -16'sd16384;
    localparam logic [14:0]        ONE_VALUE  = 15'd16384;
    localparam logic [14:0]        ZERO_VALUE = 15'd0;

    // floor(x/3) == (x * RECIP3) >> RECIP3_SHIFT for every x below 2^17
    localparam logic [15:0] RECIP3       = 16'd43691;
    localparam int          RECIP3_SHIFT = 17;

    typedef struct packed {
        logic               action;
        logic signed [15:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [14:0] pixel_out;
        logic        last_pixel;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_RD_C,
        ST_RD_N0,
        ST_RD_N1,
        ST_RD_N2,
        ST_GATHER,
        ST_SUM,
        ST_DIV,
        ST_LOAD,
        ST_WRITE
    } state_t;

    typedef enum logic [1:0] {
        RD_CENTER,
        RD_NB0,
        RD_NB1,
        RD_NB2
    } rd_sel_t;

    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_CENTER,
        CAP_NB0,
        CAP_NB1,
        CAP_NB2
    } cap_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     capture;
        rd_sel_t  rd_sel;
        cap_sel_t cap_sel;
        logic     sum_en;
        logic     div_en;
        logic     load_en;
        logic     write_en;
    } dnhf_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_drain;
        logic rcv_done;
        logic emit_ok;
        logic out_free;
    } dnhf_sts_t;

    // Clamp a written dimension to [MIN_DIM, max_dim]
    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] value,
                                                   input int max_dim);
        logic [CFG_W-1:0] res;
        res = value;
        if (value < CFG_W'(MIN_DIM)) begin
            res = CFG_W'(MIN_DIM);
        end else if (int'(value) > max_dim) begin
            res = CFG_W'(max_dim);
        end
        return res;
    endfunction

endpackage

@@ sv/dnhf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dnhf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2050
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/dnhf_ctrl.sv @@
// Hole fill sequencer: steps requests through reads, math, output and write as needed.
`timescale 1ns / 1ps
module dnhf_ctrl
    import dnhf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  dnhf_sts_t sts,
    output dnhf_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd         = '0;
        cmd.rd_sel  = RD_CENTER;
        cmd.cap_sel = CAP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (sts.is_drain) begin
                    state_next = sts.rcv_done ? ST_RD_C : ST_IDLE;
                end else if (sts.rcv_done) begin
                    state_next = ST_IDLE;       // pixel past the end of the image
                end else begin
                    state_next = sts.emit_ok ? ST_RD_C : ST_WRITE;
                end
            end
            ST_RD_C: begin
                cmd.rd_sel = RD_CENTER;
                state_next = ST_RD_N0;
            end
            ST_RD_N0: begin
                cmd.rd_sel  = RD_NB0;
                cmd.cap_sel = CAP_CENTER;
                state_next  = ST_RD_N1;
            end
            ST_RD_N1: begin
                cmd.rd_sel  = RD_NB1;
                cmd.cap_sel = CAP_NB0;
                state_next  = ST_RD_N2;
            end
            ST_RD_N2: begin
                cmd.rd_sel  = RD_NB2;
                cmd.cap_sel = CAP_NB1;
                state_next  = ST_GATHER;
            end
            ST_GATHER: begin
                cmd.cap_sel = CAP_NB2;
                state_next  = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum_en = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_en = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (sts.out_free) begin
                    cmd.load_en = 1'b1;
                    state_next  = sts.is_drain ? ST_IDLE : ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.write_en = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/dnhf_datapath.sv @@
// Datapath: geometry, frame counters, window store, neighbor average and output register.
`timescale 1ns / 1ps
module dnhf_datapath
    import dnhf_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wen,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  in_item_t         s_data,
    input  dnhf_cmd_t        cmd,
    output dnhf_sts_t        sts,
    output out_item_t        m_data,
    output logic             m_valid,
    input  logic             m_ready
);

    localparam int STORE_DEPTH = 2 * MAX_WIDTH + 2;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int PW          = AW + 1;

    // Geometry
    logic [CFG_W-1:0] eff_w_reg;
    logic [CFG_W-1:0] eff_h_reg;

    // Frame position of the next write and the next output
    logic [CFG_W-1:0] rcv_col_reg;
    logic [CFG_W-1:0] rcv_row_reg;
    logic             rcv_done_reg;
    logic [CFG_W-1:0] out_col_reg;
    logic [CFG_W-1:0] out_row_reg;
    logic [AW-1:0]    wp_reg;
    logic [AW-1:0]    rp_reg;

    // Request and window values
    logic               action_reg;
    logic signed [15:0] pix_reg;
    logic signed [15:0] center_reg;
    logic signed [15:0] nb_reg [3];

    // Arithmetic pipeline
    logic [16:0] sum_reg;
    logic [2:0]  cnt_reg;
    logic        fill_reg;
    logic [14:0] quot_reg;

    // Output register
    logic      out_valid_reg;
    out_item_t out_item_reg;

    logic [AW-1:0]      raddr;
    logic [15:0]        rdata;
    logic [PW-1:0]      rp_ext;
    logic [PW-1:0]      w_ext;
    logic [PW-1:0]      off_a;
    logic [PW-1:0]      off_b;
    logic [PW-1:0]      depth_ext;
    logic [PW-1:0]      a_nb0;
    logic [PW-1:0]      a_nb1;
    logic [PW-1:0]      a_nb2;
    logic [AW-1:0]      wp_inc;
    logic [AW-1:0]      rp_inc;
    logic               last_rcv;
    logic               last_out;
    logic               interior;
    logic [16:0]        sum_c;
    logic [2:0]         cnt_c;
    logic signed [15:0] nb_all [4];
    logic [32:0]        prod3;
    logic [14:0]        quot_c;
    logic [14:0]        pix_map;
    logic               frame_clear;

    // Window addresses around the output position, modulo the store depth
    assign rp_ext    = {1'b0, rp_reg};
    assign w_ext     = PW'(eff_w_reg);
    assign off_a     = w_ext + PW'(1);
    assign off_b     = w_ext - PW'(1);
    assign depth_ext = PW'(STORE_DEPTH);

    always_comb begin
        // up-left
        if (rp_ext >= off_a) begin
            a_nb0 = rp_ext - off_a;
        end else begin
            a_nb0 = rp_ext + depth_ext - off_a;
        end
        // up-right
        if (rp_ext >= off_b) begin
            a_nb1 = rp_ext - off_b;
        end else begin
            a_nb1 = rp_ext + depth_ext - off_b;
        end
        // down-left
        if (rp_ext + off_b >= depth_ext) begin
            a_nb2 = rp_ext + off_b - depth_ext;
        end else begin
            a_nb2 = rp_ext + off_b;
        end
    end

    always_comb begin
        unique case (cmd.rd_sel)
            RD_CENTER: raddr = rp_reg;
            RD_NB0:    raddr = a_nb0[AW-1:0];
            RD_NB1:    raddr = a_nb1[AW-1:0];
            RD_NB2:    raddr = a_nb2[AW-1:0];
            default:   raddr = rp_reg;
        endcase
    end

    assign wp_inc = (wp_reg == AW'(STORE_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
    assign rp_inc = (rp_reg == AW'(STORE_DEPTH - 1)) ? '0 : rp_reg + AW'(1);

    dnhf_ram #(
        .WIDTH(16),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (cmd.write_en),
        .waddr(wp_reg),
        .wdata(pix_reg),
        .raddr(raddr),
        .rdata(rdata)
    );

    // Frame position tests
    assign last_rcv = (rcv_row_reg == eff_h_reg - CFG_W'(1)) &&
                      (rcv_col_reg == eff_w_reg - CFG_W'(1));
    assign last_out = (out_row_reg == eff_h_reg - CFG_W'(1)) &&
                      (out_col_reg == eff_w_reg - CFG_W'(1));
    assign interior = (out_row_reg != '0) && (out_row_reg < eff_h_reg - CFG_W'(1)) &&
                      (out_col_reg != '0) && (out_col_reg < eff_w_reg - CFG_W'(1));
    assign frame_clear = cfg_wen || (cmd.load_en && last_out);

    assign sts.is_drain = (action_reg == ACT_DRAIN);
    assign sts.rcv_done = rcv_done_reg;
    assign sts.emit_ok  = (rcv_row_reg > CFG_W'(1)) ||
                          ((rcv_row_reg == CFG_W'(1)) && (rcv_col_reg != '0));
    assign sts.out_free = !out_valid_reg || m_ready;

    // Geometry registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_w_reg <= clamp_dim(CFG_W'(RESET_DIM), MAX_WIDTH);
            eff_h_reg <= clamp_dim(CFG_W'(RESET_DIM), MAX_HEIGHT);
        end else if (cfg_wen) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  eff_w_reg <= clamp_dim(cfg_wdata, MAX_WIDTH);
                REG_IMAGE_HEIGHT: eff_h_reg <= clamp_dim(cfg_wdata, MAX_HEIGHT);
                default:          eff_w_reg <= eff_w_reg;
            endcase
        end
    end

    // Frame counters and store pointers
    always_ff @(posedge aclk) begin
        if (!aresetn || frame_clear) begin
            rcv_col_reg  <= '0;
            rcv_row_reg  <= '0;
            rcv_done_reg <= 1'b0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            wp_reg       <= '0;
            rp_reg       <= '0;
        end else begin
            if (cmd.write_en) begin
                wp_reg <= wp_inc;
                if (last_rcv) begin
                    rcv_done_reg <= 1'b1;
                end
                if (rcv_col_reg == eff_w_reg - CFG_W'(1)) begin
                    rcv_col_reg <= '0;
                    rcv_row_reg <= rcv_row_reg + CFG_W'(1);
                end else begin
                    rcv_col_reg <= rcv_col_reg + CFG_W'(1);
                end
            end
            if (cmd.load_en) begin
                rp_reg <= rp_inc;
                if (out_col_reg == eff_w_reg - CFG_W'(1)) begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + CFG_W'(1);
                end else begin
                    out_col_reg <= out_col_reg + CFG_W'(1);
                end
            end
        end
    end

    // Request capture and window reads
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg <= s_data.action;
            pix_reg    <= s_data.pixel_in;
        end
        case (cmd.cap_sel)
            CAP_CENTER: center_reg <= rdata;
            CAP_NB0:    nb_reg[0]  <= rdata;
            CAP_NB1:    nb_reg[1]  <= rdata;
            CAP_NB2:    nb_reg[2]  <= rdata;
            default:    ;
        endcase
    end

    // Sum of the non-negative diagonal neighbors; down-right is the current pixel
    assign nb_all[0] = nb_reg[0];
    assign nb_all[1] = nb_reg[1];
    assign nb_all[2] = nb_reg[2];
    assign nb_all[3] = pix_reg;

    always_comb begin
        sum_c = '0;
        cnt_c = '0;
        for (int k = 0; k < 4; k++) begin
            if (!nb_all[k][15]) begin
                sum_c = sum_c + 17'(nb_all[k][14:0]);
                cnt_c = cnt_c + 3'd1;
            end
        end
    end

    // Truncated average by neighbor count
    assign prod3 = 33'(sum_reg) * 33'(RECIP3);

    always_comb begin
        case (cnt_reg)
            3'd2:    quot_c = 15'(sum_reg >> 1);
            3'd3:    quot_c = 15'(prod3 >> RECIP3_SHIFT);
            3'd4:    quot_c = 15'(sum_reg >> 2);
            default: quot_c = 15'(sum_reg);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.sum_en) begin
            sum_reg  <= sum_c;
            cnt_reg  <= cnt_c;
            fill_reg <= interior && (center_reg == HOLE_VALUE) && (cnt_c != '0);
        end
        if (cmd.div_en) begin
            quot_reg <= quot_c;
        end
    end

    // Final mapping of negative values
    always_comb begin
        if (fill_reg) begin
            pix_map = quot_reg;
        end else if (center_reg[15]) begin
            pix_map = (center_reg > HOLE_VALUE) ? ZERO_VALUE : ONE_VALUE;
        end else begin
            pix_map = center_reg[14:0];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_en) begin
            out_item_reg.pixel_out  <= pix_map;
            out_item_reg.last_pixel <= last_out;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    // A result is loaded only into a free output register
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_en |-> (!out_valid_reg || m_ready))
        else $error("result loaded over an untaken result");

    // The last pixel of the image restarts the frame
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_en && last_out && !cfg_wen) |=>
            (rcv_row_reg == '0 && rcv_col_reg == '0 && !rcv_done_reg &&
             out_row_reg == '0 && out_col_reg == '0))
        else $error("frame counters not cleared after the last pixel");

    // No store write once the whole image has arrived
    a_no_write_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write_en |-> !rcv_done_reg)
        else $error("store written past the end of the image");

    // Outputs never run ahead of the input rows
    a_out_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_en |-> (rcv_done_reg || rcv_row_reg != '0))
        else $error("result produced before its window arrived");

endmodule

@@ sv/diagonal_neighbor_hole_fill.sv @@
// Top level of the diagonal-neighbor hole fill block.
//
// Streams a grey Q1.14 image in raster order and returns it one row plus one
// pixel later; interior holes (-1.0) take the truncated mean of their
// non-negative diagonal neighbors, then negatives map to 0 (above -1.0) or
// 1.0. Requests are handled one at a time by a sequencer around a single
// window store of 2*MAX_WIDTH+2 entries, which gets no clearing pass after
// reset. The four window reads go one per cycle through that store's single
// read port. A finished result waits in the output register while the next
// request is taken; a later result is loaded only once that register is free.
// Drain requests (action = 1) release the last row plus one pixel once the
// whole image is in. Writing a geometry register restarts the frame.
`timescale 1ns / 1ps
module diagonal_neighbor_hole_fill
    import dnhf_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    // configuration writes
    input  logic             cfg_wen,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    // input requests
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    // results
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data
);

    dnhf_cmd_t cmd;
    dnhf_sts_t sts;

    dnhf_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    dnhf_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wen  (cfg_wen),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_data   (s_data),
        .cmd      (cmd),
        .sts      (sts),
        .m_data   (m_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready)
    );

endmodule
